/* sv/lphi_pkg.sv */
`timescale 1ns / 1ps
package lphi_pkg;

  // Table depth must be a power of two; slot arithmetic wraps on the address width.
  localparam int TABLE_DEPTH = 8192;
  localparam int ADDR_W      = $clog2(TABLE_DEPTH);
  localparam int KEY_W       = 32;
  localparam int CAP_W       = 13;
  localparam int SLOT_W      = 13;
  localparam int COUNT_W     = 13;
  localparam int TDATA_W     = 32;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(6144);
  localparam logic [KEY_W-1:0] HASH_MULT = 32'd2654435761;

  typedef enum logic [1:0] {
    ST_NONE     = 2'd0,
    ST_HIT      = 2'd1,
    ST_INSERTED = 2'd2,
    ST_FULL     = 2'd3
  } status_t;

  typedef struct packed {
    logic    load_in;
    logic    hash;
    logic    rd;
    logic    adv;
    logic    ins;
    logic    clr_wr;
    logic    set_res;
    status_t res_code;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    logic key_valid;
    logic match;
    logic empty;
    logic cap_reached;
    logic probe_last;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

/* sv/lphi_ram.sv */
`timescale 1ns / 1ps
module lphi_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* sv/lphi_ctrl.sv */
`timescale 1ns / 1ps
module lphi_ctrl
  import lphi_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HASH,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    cmd.res_code = ST_NONE;
    unique case (state)
      S_CLEAR: begin
        cmd.clr_wr = 1'b1;
        if (stat.clr_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_next  = S_HASH;
        end
      end
      S_HASH: begin
        if (stat.key_valid) begin
          cmd.hash   = 1'b1;
          state_next = S_READ;
        end else begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_NONE;
          state_next   = S_DONE;
        end
      end
      S_READ: begin
        cmd.rd     = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        priority if (stat.match) begin
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_HIT;
          state_next   = S_DONE;
        end else if (stat.empty) begin
          cmd.set_res = 1'b1;
          if (stat.cap_reached) begin
            cmd.res_code = ST_FULL;
          end else begin
            cmd.ins      = 1'b1;
            cmd.res_code = ST_INSERTED;
          end
          state_next = S_DONE;
        end else if (stat.probe_last) begin
          // whole table walked, no room
          cmd.set_res  = 1'b1;
          cmd.res_code = ST_FULL;
          state_next   = S_DONE;
        end else begin
          cmd.adv    = 1'b1;
          state_next = S_READ;
        end
      end
      S_DONE: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

endmodule

/* sv/lphi_dp.sv */
`timescale 1ns / 1ps
module lphi_dp
  import lphi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  cmd_t               cmd,
  output stat_t              stat,
  input  logic [KEY_W-1:0]   in_key,
  input  logic               in_present,
  input  logic               cfg_wen,
  input  logic [CAP_W-1:0]   cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output status_t            out_status,
  output logic [SLOT_W-1:0]  out_slot,
  output logic [COUNT_W-1:0] out_count
);

  localparam logic [ADDR_W-1:0] HASH_LO = HASH_MULT[ADDR_W-1:0];

  logic [KEY_W-1:0]   key_r;
  logic               present_r;
  logic [ADDR_W-1:0]  slot;
  logic [ADDR_W-1:0]  probe;
  logic [ADDR_W-1:0]  clr_addr;
  logic [COUNT_W-1:0] entry_count;
  logic [CAP_W-1:0]   capacity;
  status_t            res_code;
  logic [SLOT_W-1:0]  res_slot;

  logic [ADDR_W-1:0]  hash_slot;
  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr;
  logic [KEY_W-1:0]   ram_wdata;
  logic [KEY_W-1:0]   rd_data;

  // home slot: low bits of key * multiplier depend only on low bits of both
  assign hash_slot = key_r[ADDR_W-1:0] * HASH_LO;

  assign ram_we    = cmd.clr_wr | cmd.ins;
  assign ram_waddr = cmd.clr_wr ? clr_addr : slot;
  assign ram_wdata = cmd.clr_wr ? '0 : key_r;

  lphi_ram #(
    .WIDTH (KEY_W),
    .DEPTH (TABLE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd.rd),
    .raddr (slot),
    .rdata (rd_data)
  );

  assign stat.key_valid   = (key_r != '0) && present_r;
  assign stat.match       = (rd_data == key_r);
  assign stat.empty       = (rd_data == '0);
  assign stat.cap_reached = (entry_count >= capacity);
  assign stat.probe_last  = &probe;
  assign stat.clr_last    = &clr_addr;
  assign stat.out_free    = !out_valid || out_ready;

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr    <= '0;
      entry_count <= '0;
      capacity    <= CAP_RESET;
      out_valid   <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + ADDR_W'(1);
      end
      if (cmd.ins) begin
        entry_count <= entry_count + COUNT_W'(1);
      end
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      key_r     <= in_key;
      present_r <= in_present;
    end
    if (cmd.hash) begin
      slot  <= hash_slot;
      probe <= '0;
    end else if (cmd.adv) begin
      slot  <= slot + ADDR_W'(1);
      probe <= probe + ADDR_W'(1);
    end
    if (cmd.set_res) begin
      res_code <= cmd.res_code;
      res_slot <= (cmd.res_code == ST_HIT || cmd.res_code == ST_INSERTED) ?
                  SLOT_W'(slot) : '0;
    end
    if (cmd.out_load) begin
      out_status <= res_code;
      out_slot   <= res_slot;
      out_count  <= entry_count;
    end
  end

endmodule

/* sv/linear_probe_hash_insert_lookup.sv */
`timescale 1ns / 1ps
// Linear-probing hash table: lookup with insert on miss.
// Input stream: s_tdata carries the 32-bit key, s_tuser the source-present
// flag. One result per request on the output stream: m_tuser is the status
// (none, hit, inserted, full), m_tdata holds the slot and the stored count.
// The capacity register is written through cfg_wen / cfg_wdata; the user must
// write it only while idle, as the block does not enforce this. Sequence: one
// request at a time. A request with a zero key or no source skips the hash and
// goes straight to its result. Otherwise the home slot is hashed into a
// register, then each probe is a registered read of the single key store and
// a compare and possible write; probing stops at the key, at an empty slot or
// when the whole table has been walked. The result then waits for a free
// output register; the next request is taken once it loads.
// Reset: rst clears the count and restores the capacity to 6144, then the key
// store is cleared one slot per cycle, all 8192 slots, with s_tready low.
// Stall: the result sits in an output register; a new request is taken while
// it waits, and that one's result holds until m_tready frees the register.
module linear_probe_hash_insert_lookup
  import lphi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [KEY_W-1:0]   s_tdata,   // [31:0] key
  input  logic               s_tuser,   // [0] source_present
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [12:0] slot_index, [25:13] stored_count, zeros
  output logic [1:0]         m_tuser,   // [1:0] status
  input  logic               cfg_wen,
  input  logic [CAP_W-1:0]   cfg_wdata
);

  cmd_t               cmd;
  stat_t              stat;
  status_t            out_status;
  logic [SLOT_W-1:0]  out_slot;
  logic [COUNT_W-1:0] out_count;

  lphi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  lphi_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .in_key     (s_tdata),
    .in_present (s_tuser),
    .cfg_wen    (cfg_wen),
    .cfg_wdata  (cfg_wdata),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_status (out_status),
    .out_slot   (out_slot),
    .out_count  (out_count)
  );

  assign m_tdata = {{(TDATA_W - COUNT_W - SLOT_W){1'b0}}, out_count, out_slot};
  assign m_tuser = out_status;

endmodule

/* sv/lphi_checker.sv */
`timescale 1ns / 1ps
module lphi_checker
  import lphi_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic [1:0]         m_tuser
);

  // result holds while the receiver stalls
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed under stall");

  // reset starts the store clear, so no request is taken just after
  a_reset_busy: assert property (@(posedge clk)
    rst |=> !s_tready)
    else $error("input ready right after reset");

  // one request in work at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second request taken back to back");

  // none and full carry slot zero
  a_slot_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tuser == ST_NONE || m_tuser == ST_FULL) |-> m_tdata[SLOT_W-1:0] == '0)
    else $error("nonzero slot on none or full");

  // an insert leaves at least one stored key
  a_insert_count: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == ST_INSERTED |-> m_tdata[SLOT_W+COUNT_W-1:SLOT_W] != '0)
    else $error("insert with zero count");

endmodule

bind linear_probe_hash_insert_lookup lphi_checker u_lphi_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

/* test/probe_result_checker.sv */
`timescale 1ns / 1ps
module probe_result_checker
  import lphi_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  input  logic               s_tready,
  input  logic [KEY_W-1:0]   s_tdata,
  input  logic               s_tuser,
  input  logic               m_tvalid,
  input  logic               m_tready,
  input  logic [TDATA_W-1:0] m_tdata,
  input  logic [1:0]         m_tuser,
  input  logic               cfg_wen,
  input  logic [CAP_W-1:0]   cfg_wdata,
  output int                 owed,
  output int                 mismatches,
  output int                 hits_seen,
  output int                 inserts_seen,
  output int                 refusals_seen
);

  typedef struct packed {
    status_t            status;
    logic [SLOT_W-1:0]  slot;
    logic [COUNT_W-1:0] count;
  } lookup_result_t;

  logic [KEY_W-1:0]   key_mem [TABLE_DEPTH];
  logic [COUNT_W-1:0] held_count;
  logic [CAP_W-1:0]   cap;
  lookup_result_t     lookups_due [$];
  int                 n_err = 0;
  int                 n_hit = 0;
  int                 n_ins = 0;
  int                 n_full = 0;

  // Walk from the home slot; stop at key, first empty slot or full lap.
  task automatic probe_table(input logic [KEY_W-1:0] k, input logic present,
                             output lookup_result_t r);
    logic [KEY_W-1:0]  product;
    logic [ADDR_W-1:0] at;
    bit                done;
    r.status = ST_NONE;
    r.slot = '0;
    if (k != '0 && present) begin
      product = k * HASH_MULT;
      at = product[ADDR_W-1:0];
      r.status = ST_FULL;
      done = 1'b0;
      for (int n = 0; n < TABLE_DEPTH && !done; n++) begin
        if (key_mem[at] == k) begin
          r.status = ST_HIT;
          r.slot = at;
          done = 1'b1;
        end else if (key_mem[at] == '0) begin
          if (held_count < cap) begin
            key_mem[at] = k;
            held_count = held_count + 1'b1;
            r.status = ST_INSERTED;
            r.slot = at;
          end
          done = 1'b1;
        end else begin
          at = at + 1'b1;
        end
      end
    end
    r.count = held_count;
  endtask

  always @(posedge clk) begin
    lookup_result_t want;
    if (rst) begin
      for (int i = 0; i < TABLE_DEPTH; i++) key_mem[i] = '0;
      held_count = '0;
      cap = CAP_RESET;
      lookups_due.delete();
    end else begin
      if (cfg_wen) cap = cfg_wdata;
      if (m_tvalid && m_tready) begin
        if (lookups_due.size() == 0) begin
          n_err++;
          $error("result with no request outstanding: status %0d tdata %h", m_tuser, m_tdata);
        end else begin
          want = lookups_due.pop_front();
          case (want.status)
            ST_HIT:      n_hit++;
            ST_INSERTED: n_ins++;
            ST_FULL:     n_full++;
            default:     ;
          endcase
          if (m_tuser !== want.status) begin
            n_err++;
            $error("status: expected %0d, got %0d", want.status, m_tuser);
          end
          if (m_tdata[SLOT_W-1:0] !== want.slot) begin
            n_err++;
            $error("slot_index: expected %0d, got %0d", want.slot, m_tdata[SLOT_W-1:0]);
          end
          if (m_tdata[SLOT_W+COUNT_W-1:SLOT_W] !== want.count) begin
            n_err++;
            $error("stored_count: expected %0d, got %0d", want.count,
                   m_tdata[SLOT_W+COUNT_W-1:SLOT_W]);
          end
          if (m_tdata[TDATA_W-1:SLOT_W+COUNT_W] !== '0) begin
            n_err++;
            $error("tdata pad: expected 0, got %h", m_tdata[TDATA_W-1:SLOT_W+COUNT_W]);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        probe_table(s_tdata, s_tuser, want);
        lookups_due.push_back(want);
      end
    end
    owed <= lookups_due.size();
    mismatches <= n_err;
    hits_seen <= n_hit;
    inserts_seen <= n_ins;
    refusals_seen <= n_full;
  end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
module tb;
  import lphi_pkg::*;

  localparam logic [CAP_W-1:0] CAP_MAX = {CAP_W{1'b1}};
  localparam int CHUNK_ITEMS = 125;
  localparam int N_CHUNKS    = 6;
  localparam int N_CLUSTERS  = 7;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [KEY_W-1:0]   s_tdata = '0;
  logic               s_tuser = 1'b0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic [1:0]         m_tuser;
  logic               cfg_wen = 1'b0;
  logic [CAP_W-1:0]   cfg_wdata = '0;

  int owed, mismatches, hits_seen, inserts_seen, refusals_seen;
  int src_idle_pct = 23;
  int sink_idle_pct = 63;
  int sent = 0;
  int settings = 0;
  logic [KEY_W-1:0] offered_keys [$];

  initial begin
    forever #5 clk = ~clk;
  end

  linear_probe_hash_insert_lookup u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_wen   (cfg_wen),
    .cfg_wdata (cfg_wdata)
  );

  probe_result_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .s_tuser       (s_tuser),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .owed          (owed),
    .mismatches    (mismatches),
    .hits_seen     (hits_seen),
    .inserts_seen  (inserts_seen),
    .refusals_seen (refusals_seen)
  );

  always @(posedge clk) m_tready <= ($urandom_range(99) >= sink_idle_pct);

  task automatic send_item(input logic [KEY_W-1:0] k, input logic present);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= k;
    s_tuser <= present;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sent++;
    if (present && k != '0) offered_keys.push_back(k);
  endtask

  // Hold off the sender until every outstanding result is back.
  task automatic drain;
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (owed != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CAP_W-1:0] v);
    drain();
    cfg_wen <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_wen <= 1'b0;
    settings++;
  endtask

  initial begin
    logic [KEY_W-1:0] k;
    logic [KEY_W-1:0] product;
    logic             p;
    logic [ADDR_W-1:0] wrap_low;
    logic [ADDR_W-1:0] cluster_low [N_CLUSTERS];
    logic [CAP_W-1:0] cap_v;
    int               r;

    // Low key bits whose home slot is the last one, for a run that wraps.
    wrap_low = '0;
    for (int v = 0; v < TABLE_DEPTH; v++) begin
      product = 32'(v) * HASH_MULT;
      if (product[ADDR_W-1:0] == '1) wrap_low = ADDR_W'(v);
    end
    for (int c = 0; c < N_CLUSTERS - 1; c++) cluster_low[c] = ADDR_W'($urandom);
    cluster_low[N_CLUSTERS-1] = wrap_low;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero key, absent source, extremes, collisions, wrap.
    send_item('0, 1'b1);
    send_item('1, 1'b0);
    send_item(32'd1, 1'b1);
    send_item(32'd1, 1'b1);
    send_item('1, 1'b1);
    send_item(32'h8000_0000, 1'b1);
    send_item(32'h0000_2000, 1'b1);
    send_item(32'hFFFF_E000, 1'b1);
    send_item(32'h0000_2000, 1'b1);
    for (int j = 0; j < 3; j++) send_item({19'($urandom), wrap_low}, 1'b1);
    send_item({19'h7FFFF, wrap_low}, 1'b1);
    send_item(32'd1, 1'b0);

    // Capacity zero: lookups still hit, new keys are refused.
    write_capacity('0);
    send_item(32'd1, 1'b1);
    send_item(32'h1234_5678, 1'b1);
    send_item('0, 1'b0);
    send_item(32'h0000_2000, 1'b1);

    for (int chunk = 0; chunk < N_CHUNKS; chunk++) begin
      case (chunk)
        0: cap_v = CAP_W'(inserts_seen + 25);
        1: cap_v = CAP_MAX;
        2: cap_v = CAP_W'(1);
        3: cap_v = CAP_W'(inserts_seen + 15);
        4: cap_v = CAP_W'($urandom_range(int'(CAP_MAX), inserts_seen));
        default: cap_v = CAP_RESET;
      endcase
      if (chunk < 2) begin
        src_idle_pct = 23;
        sink_idle_pct = 63;
      end else if (chunk < 4) begin
        src_idle_pct = 63;
        sink_idle_pct = 23;
      end else begin
        src_idle_pct = 0;
        sink_idle_pct = 0;
      end
      write_capacity(cap_v);
      for (int i = 0; i < CHUNK_ITEMS; i++) begin
        r = $urandom_range(99);
        p = 1'b1;
        if (r < 6) begin
          k = $urandom;
          p = 1'b0;
        end else if (r < 10) begin
          k = '0;
          p = 1'($urandom);
        end else if (r < 45 && offered_keys.size() > 0) begin
          k = offered_keys[$urandom_range(offered_keys.size() - 1)];
        end else if (r < 75) begin
          // Same low bits give the same home slot: build probe runs.
          k = {19'($urandom), cluster_low[$urandom_range(N_CLUSTERS - 1)]};
          if (k == '0) k = 32'h0000_2000;
        end else begin
          k = $urandom;
          if (k == '0) k = 32'hDEAD_0001;
        end
        send_item(k, p);
      end
    end

    drain();
    repeat (20) @(posedge clk);
    $display("tb: %0d requests over %0d capacity settings and three idle profiles",
             sent, settings);
    $display("tb: %0d hits, %0d inserts, %0d refused as full",
             hits_seen, inserts_seen, refusals_seen);
    if (mismatches == 0 && owed == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

endmodule
